FILE: src/vtx4_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 4x4 vertex transform pipeline.
// No dependencies; imported by vertex_transform_4x4_top, the checker and the testbench.

package vtx4_pkg;

    // Component width and default fraction bits of the fixed-point format
    localparam int DW            = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Matrix geometry
    localparam int DIM   = 4;
    localparam int MAT_N = DIM * DIM;
    localparam int IDX_W = 4;

    // Stream payload widths
    localparam int OP_W         = 2;
    localparam int IN_FIELDS_W  = IDX_W + 5 * DW;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = DIM * DW;

    // Arithmetic widths: exact product, pair sum, full row sum plus rounding
    localparam int PROD_W = 2 * DW;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    // Request kinds carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_VEC4  = 2'd1,
        OP_POINT = 2'd2,
        OP_DIR   = 2'd3
    } op_t;

endpackage

FILE: src/vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// Pipelined 4x4 matrix by homogeneous vector multiply in signed fixed point.
// Depends on vtx4_pkg for widths, request kinds and arithmetic sizes.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the request kind. A load request
//   writes one column-major matrix element (column*4+row) and gives no
//   output. Vec4, point and direction requests each give one output with
//   the transformed x, y, z, w and an overflow flag in tuser. Point forces
//   w to 1.0, direction forces w to 0.
//   Output stream (m_axis_*): each component is the exact sum of four
//   products, rounded half up to FRAC_BITS fraction bits and saturated.
//   Pipeline: a transform request taken on s_axis passes the stage 1
//   operand register, stage 2 sixteen 32x32 multipliers, stage 3 pair adds,
//   stage 4 row add plus rounding constant and the output register with
//   shift and saturation before it is shown on m_axis.
//   Throughput: one request per cycle, loads included, while m_axis_tready
//   is high; a load written in stage 1 is seen by every transform after it.
//   Stall: while m_axis_tready is low the pipeline fills its empty stages
//   and s_axis_tready drops only when every stage holds a transform.
//   Reset: the pipeline empties and the matrix returns to the identity.

module vertex_transform_4x4_top
    import vtx4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: element_index[3:0], element_value[35:4], vec_x[67:36],
    //        vec_y[99:68], vec_z[131:100], vec_w[163:132], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    // Output result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: overflow[0]
    output logic [0:0]             m_axis_tuser
);

    localparam logic signed [DW-1:0] ONE_FIX = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF_LSB =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    // Input field unpacking
    op_t                     in_op;
    logic [IDX_W-1:0]        in_idx;
    logic signed [DW-1:0]    in_val;
    logic signed [DW-1:0]    in_vec [DIM];

    // Pipeline state
    logic                    v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    op_t                     op1_reg;
    logic [IDX_W-1:0]        idx1_reg;
    logic signed [DW-1:0]    val1_reg;
    logic signed [DW-1:0]    vec1_reg [DIM];
    logic signed [DW-1:0]    mat_reg [MAT_N];
    logic signed [PROD_W-1:0] prod_reg [DIM][DIM];
    logic signed [PROD_W-1:0] prod_next [DIM][DIM];
    logic signed [PAIR_W-1:0] pair_reg [DIM][2];
    logic signed [PAIR_W-1:0] pair_next [DIM][2];
    logic signed [SUM_W-1:0]  sum_reg [DIM];
    logic signed [SUM_W-1:0]  sum_next [DIM];
    logic [OUT_TDATA_W-1:0]  out_reg, out_next;
    logic                    ovf_reg, ovf_next;

    // Stage acceptance
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic s_fire, load1;

    assign in_op     = op_t'(s_axis_tuser);
    assign in_idx    = s_axis_tdata[IDX_W-1:0];
    assign in_val    = s_axis_tdata[IDX_W +: DW];

    // Unpack x, y, z and pick w by request kind
    always_comb
    begin
        in_vec[0] = s_axis_tdata[IDX_W + DW +: DW];
        in_vec[1] = s_axis_tdata[IDX_W + 2*DW +: DW];
        in_vec[2] = s_axis_tdata[IDX_W + 3*DW +: DW];
        unique case (in_op)
            OP_VEC4:  in_vec[3] = s_axis_tdata[IDX_W + 4*DW +: DW];
            OP_POINT: in_vec[3] = ONE_FIX;
            OP_DIR:   in_vec[3] = '0;
            OP_LOAD:  in_vec[3] = '0;
            default:  in_vec[3] = '0;
        endcase
    end

    // Ready chain: a stage takes new data when empty or when it moves on
    assign load1  = (op1_reg == OP_LOAD);
    assign rdy5   = !vo_reg || m_axis_tready;
    assign rdy4   = !v4_reg || rdy5;
    assign rdy3   = !v3_reg || rdy4;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || load1 || rdy2;
    assign s_fire = s_axis_tvalid && rdy1;
    assign s_axis_tready = rdy1;

    // Stage 1 valid and matrix store; a load leaves stage 1 by writing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int i = 0; i < MAT_N; i++)
            begin
                mat_reg[i] <= (i % 5 == 0) ? ONE_FIX : '0;
            end
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_fire;
            end
            if (v1_reg && load1)
            begin
                mat_reg[idx1_reg] <= val1_reg;
            end
        end
    end

    // Stage 1 operands
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op1_reg  <= in_op;
            idx1_reg <= in_idx;
            val1_reg <= in_val;
            for (int c = 0; c < DIM; c++)
            begin
                vec1_reg[c] <= in_vec[c];
            end
        end
    end

    // Stage 2: sixteen exact products, row r and column c
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_next[r][c] = mat_reg[c*DIM + r] * vec1_reg[c];
            end
        end
    end

    // Stage 3: pair sums per row
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            pair_next[r][0] = PAIR_W'(prod_reg[r][0]) + PAIR_W'(prod_reg[r][1]);
            pair_next[r][1] = PAIR_W'(prod_reg[r][2]) + PAIR_W'(prod_reg[r][3]);
        end
    end

    // Stage 4: full row sum with half an LSB added for rounding
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            sum_next[r] = SUM_W'(pair_reg[r][0]) + SUM_W'(pair_reg[r][1]) + HALF_LSB;
        end
    end

    // Output stage: drop fraction bits and saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] shifted;
        logic [SUM_W-DW:0]       upper;
        logic                    fits;
        out_next = '0;
        ovf_next = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            shifted = sum_reg[r] >>> FRAC_BITS;
            upper   = shifted[SUM_W-1:DW-1];
            fits    = (&upper) || !(|upper);
            if (fits)
            begin
                out_next[r*DW +: DW] = shifted[DW-1:0];
            end
            else
            begin
                out_next[r*DW +: DW] = sum_reg[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
                ovf_next = 1'b1;
            end
        end
    end

    // Valid bits of stages 2 to output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= v1_reg && !load1;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // Datapath registers of stages 2 to output
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            prod_reg <= prod_next;
        end
        if (rdy3)
        begin
            pair_reg <= pair_next;
        end
        if (rdy4)
        begin
            sum_reg <= sum_next;
        end
        if (rdy5)
        begin
            out_reg <= out_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_axis_tvalid   = vo_reg;
    assign m_axis_tdata    = out_reg;
    assign m_axis_tuser[0] = ovf_reg;

    // Input stalls only with every stage holding a stalled transform
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && !load1 && v2_reg && v3_reg && v4_reg
                            && vo_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    // A stage 4 item blocked by the output stays in place
    a_hold_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !rdy5) |=> v4_reg)
        else $error("stage 4 item lost during output stall");

    // A load leaving stage 1 never turns into a product
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && load1 && rdy2) |=> !v2_reg)
        else $error("load request entered the multiply stage");

    // A transform leaving stage 1 always reaches stage 2
    a_xform_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !load1 && rdy2) |=> v2_reg)
        else $error("transform request dropped after stage 1");

endmodule

FILE: sim/vertex_transform_checker.sv
`timescale 1ns / 1ps
// Stream checker for vertex_transform_4x4_top: tracks matrix loads, predicts
// each transformed vertex and compares it with the output stream.
// Depends on vtx4_pkg for widths and request kinds.

module vertex_transform_checker
    import vtx4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // tdata: element_index, element_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation
    input  logic [OP_W-1:0]        s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: out_x, out_y, out_z, out_w
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: overflow
    input  logic [0:0]             m_axis_tuser,
    output int                     mismatch_count,
    output int                     pending_count
);

    typedef logic signed [DW-1:0] fix_t;

    // Exact row sum of four products plus rounding, with headroom
    localparam int ACC_W = 2 * DW + 4;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
        fix_t w;
        logic ovf;
    } vertex_t;

    // Field offsets in the request tdata
    localparam int VAL_LSB = IDX_W;
    localparam int X_LSB   = IDX_W + DW;
    localparam int Y_LSB   = IDX_W + 2 * DW;
    localparam int Z_LSB   = IDX_W + 3 * DW;
    localparam int W_LSB   = IDX_W + 4 * DW;

    localparam fix_t FIX_ONE  = fix_t'(1) <<< FRAC_BITS_DEF;
    localparam acc_t HALF_LSB = acc_t'(1) <<< (FRAC_BITS_DEF - 1);
    localparam acc_t SAT_HI   = (acc_t'(1) <<< (DW - 1)) - 1;
    localparam acc_t SAT_LO   = -(acc_t'(1) <<< (DW - 1));

    fix_t    matrix_copy [MAT_N];
    vertex_t expected_vertices [$];
    int      error_total;

    // Multiply the held matrix by one vector; round half up, then saturate
    function automatic vertex_t transform_vertex(input op_t op, input fix_t vx,
                                                 input fix_t vy, input fix_t vz,
                                                 input fix_t vw);
        fix_t    vin [DIM];
        fix_t    comp [DIM];
        acc_t    acc;
        acc_t    rnd;
        acc_t    elem;
        acc_t    term;
        logic    ovf;
        int      row;
        int      col;
        vertex_t res;
        vin[0] = vx;
        vin[1] = vy;
        vin[2] = vz;
        vin[3] = (op == OP_VEC4) ? vw : (op == OP_POINT) ? FIX_ONE : '0;
        ovf = 1'b0;
        for (row = 0; row < DIM; row++)
        begin
            acc = '0;
            for (col = 0; col < DIM; col++)
            begin
                elem = matrix_copy[col * DIM + row];
                term = vin[col];
                acc  = acc + elem * term;
            end
            rnd = (acc + HALF_LSB) >>> FRAC_BITS_DEF;
            if (rnd > SAT_HI)
            begin
                comp[row] = SAT_HI[DW-1:0];
                ovf = 1'b1;
            end
            else if (rnd < SAT_LO)
            begin
                comp[row] = SAT_LO[DW-1:0];
                ovf = 1'b1;
            end
            else
                comp[row] = rnd[DW-1:0];
        end
        res.x   = comp[0];
        res.y   = comp[1];
        res.z   = comp[2];
        res.w   = comp[3];
        res.ovf = ovf;
        return res;
    endfunction

    // Compare each output with the oldest prediction, then take the new request
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t want;
        vertex_t seen;
        if (!rst_n)
        begin
            expected_vertices.delete();
            for (int i = 0; i < MAT_N; i++)
                matrix_copy[i] = (i % (DIM + 1) == 0) ? FIX_ONE : '0;
            error_total    = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.x   = m_axis_tdata[0 +: DW];
                seen.y   = m_axis_tdata[DW +: DW];
                seen.z   = m_axis_tdata[2 * DW +: DW];
                seen.w   = m_axis_tdata[3 * DW +: DW];
                seen.ovf = m_axis_tuser[0];
                if (expected_vertices.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: result with none pending: x=%h y=%h z=%h w=%h ovf=%b",
                                 $realtime, seen.x, seen.y, seen.z, seen.w, seen.ovf);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (want !== seen)
                    begin
                        error_total++;
                        if (error_total <= 10)
                        begin
                            $display("%0t: vertex mismatch", $realtime);
                            $display("  exp x=%h y=%h z=%h w=%h ovf=%b",
                                     want.x, want.y, want.z, want.w, want.ovf);
                            $display("  got x=%h y=%h z=%h w=%h ovf=%b",
                                     seen.x, seen.y, seen.z, seen.w, seen.ovf);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (op_t'(s_axis_tuser) == OP_LOAD)
                    matrix_copy[s_axis_tdata[0 +: IDX_W]] = s_axis_tdata[VAL_LSB +: DW];
                else
                    expected_vertices.push_back(transform_vertex(op_t'(s_axis_tuser),
                                                                 s_axis_tdata[X_LSB +: DW],
                                                                 s_axis_tdata[Y_LSB +: DW],
                                                                 s_axis_tdata[Z_LSB +: DW],
                                                                 s_axis_tdata[W_LSB +: DW]));
            end
            mismatch_count <= error_total;
            pending_count  <= expected_vertices.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the vertex transform test: clock, reset, request stimulus and verdict.
// Depends on vtx4_pkg, vertex_transform_4x4_top and vertex_transform_checker.

module testbench;
    import vtx4_pkg::*;

    localparam int IDLE_PCT      = 36;
    localparam int RANDOM_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [DW-1:0] FIX_MAX     = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] FIX_MIN     = 32'h8000_0000;
    localparam logic [DW-1:0] FIX_ONE     = 32'h0001_0000;
    localparam logic [DW-1:0] FIX_NEG_ONE = 32'hFFFF_0000;
    localparam logic [DW-1:0] FIX_HALF    = 32'h0000_8000;
    localparam logic [DW-1:0] FIX_NEG_HLF = 32'hFFFF_8000;
    localparam logic [DW-1:0] FIX_LSB     = 32'h0000_0001;
    localparam logic [DW-1:0] FIX_ALL_ONE = 32'hFFFF_FFFF;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = OP_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    logic idle_on = 1'b1;
    int   mismatch_count;
    int   pending_count;
    int   request_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    vertex_transform_4x4_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vertex_transform_checker vertex_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Stall the output stream at random while idling is on
    always @(posedge clk)
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);

    // Hold off at random, then present one request until it is taken
    task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                                input logic [DW-1:0] value, input logic [DW-1:0] vx,
                                input logic [DW-1:0] vy, input logic [DW-1:0] vz,
                                input logic [DW-1:0] vw);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({vw, vz, vy, vx, value, idx});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        request_count++;
    endtask

    // Write one matrix element; the vector fields carry noise
    task automatic load_element(input logic [IDX_W-1:0] idx, input logic [DW-1:0] value);
        send_request(OP_LOAD, idx, value, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Send one vector; index and value carry noise
    task automatic transform(input op_t op, input logic [DW-1:0] vx, input logic [DW-1:0] vy,
                             input logic [DW-1:0] vz, input logic [DW-1:0] vw);
        send_request(op, IDX_W'($urandom), $urandom, vx, vy, vz, vw);
    endtask

    // Drop valid and hold until every pending vertex has come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Mix of extremes, unit values, small values and full-range noise
    function automatic logic [DW-1:0] pick_fixed();
        unique case ($urandom_range(0, 9))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? FIX_ONE : FIX_NEG_ONE;
            4, 5, 6,
            7:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int base;
        int k;
        int choice;
        logic pressed_early;
        logic pressed_late;
        pressed_early = 1'b0;
        pressed_late  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix: all three kinds, extremes pass through unchanged
        transform(OP_VEC4, FIX_MAX, FIX_MIN, '0, FIX_ALL_ONE);
        transform(OP_POINT, FIX_LSB, FIX_ALL_ONE, FIX_ONE, FIX_ALL_ONE);
        transform(OP_DIR, FIX_MIN, FIX_MAX, FIX_NEG_ONE, FIX_MAX);
        transform(OP_VEC4, '0, '0, '0, '0);

        // Column 0: tiny, minus one LSB, zero, largest
        load_element(4'd0, FIX_LSB);
        load_element(4'd1, FIX_ALL_ONE);
        load_element(4'd2, '0);
        load_element(4'd3, FIX_MAX);

        // Rounding ties in both directions, then saturation from the w row only
        transform(OP_VEC4, FIX_HALF, '0, '0, '0);
        transform(OP_VEC4, FIX_NEG_HLF, '0, '0, '0);
        transform(OP_POINT, FIX_MAX, '0, '0, FIX_ALL_ONE);
        transform(OP_DIR, FIX_MIN, '0, '0, FIX_MAX);

        // Column 3: extremes show up directly in point mode
        load_element(4'd12, FIX_MIN);
        load_element(4'd15, FIX_MAX);
        transform(OP_POINT, '0, '0, '0, FIX_MAX);
        transform(OP_DIR, '0, '0, '0, FIX_MAX);
        transform(OP_VEC4, '0, '0, '0, FIX_MIN);

        // Random phase: reloads, single loads and vectors
        base = request_count;
        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            idle_on <= !(k >= 250 && k < 400);
            if (k >= 150 && !pressed_early)
            begin
                pressed_early = 1'b1;
                wait_for_results();
            end
            if (k >= 450 && !pressed_late)
            begin
                pressed_late = 1'b1;
                wait_for_results();
            end
            choice = $urandom_range(0, 99);
            if (choice < 4)
            begin
                for (int e = 0; e < MAT_N; e++)
                    load_element(IDX_W'(e), pick_fixed());
            end
            else if (choice < 22)
                load_element(IDX_W'($urandom_range(0, MAT_N - 1)), pick_fixed());
            else
                transform(op_t'($urandom_range(1, 3)), pick_fixed(), pick_fixed(),
                          pick_fixed(), pick_fixed());
            k = request_count - base;
        end

        // Drain and let the pipeline settle before the verdict
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("vertex_transform_4x4_top test passed");
        else
            $display("vertex_transform_4x4_top test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("vertex_transform_4x4_top test failed");
        $finish;
    end

endmodule
